// File: src/orsp_pkg.sv
// Package for the object record stream parser: channel payload types, event
// and phase codes, record opcodes and small helper functions.
// No dependencies.
`default_nettype none

package orsp_pkg;

   localparam logic [7:0] OP_END       = 8'h00;
   localparam logic [7:0] OP_CONST_MAX = 8'hDF;
   localparam logic [7:0] OP_RELOC     = 8'hE2;
   localparam logic [7:0] OP_INTERSEG  = 8'hE3;
   localparam logic [7:0] OP_DS        = 8'hF1;
   localparam logic [7:0] OP_LCONST    = 8'hF2;
   localparam logic [7:0] OP_CRELOC    = 8'hF5;
   localparam logic [7:0] OP_CINTERSEG = 8'hF6;
   localparam logic [7:0] OP_SUPER     = 8'hF7;

   localparam int         FIELD_DEPTH  = 14;
   localparam logic [7:0] NUMLEN_RESET = 8'd4;
   localparam logic [7:0] SKIP_FLAG    = 8'h80;
   localparam logic [6:0] SKIP_MASK    = 7'h7F;
   localparam logic [15:0] PAGE_STEP   = 16'h0100;

   typedef enum logic [3:0] {
      EV_CONST        = 4'd0,
      EV_DS           = 4'd1,
      EV_LCONST       = 4'd2,
      EV_RELOC        = 4'd3,
      EV_INTERSEG     = 4'd4,
      EV_CRELOC       = 4'd5,
      EV_CINTERSEG    = 4'd6,
      EV_SUPER_HEADER = 4'd7,
      EV_SUPER_SKIP   = 4'd8,
      EV_SUPER_PATCH  = 4'd9,
      EV_END          = 4'd10,
      EV_UNSUPPORTED  = 4'd11,
      EV_SUPER_ERROR  = 4'd12,
      EV_SUPER_DONE   = 4'd13
   } event_type;

   typedef enum logic [2:0] {
      PH_OP     = 3'd0,
      PH_FIELDS = 3'd1,
      PH_SKIP   = 3'd2,
      PH_SBODY  = 3'd3,
      PH_SOFFS  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       body_start;
   } req_type;

   typedef struct packed {
      logic [3:0]        event_res;
      logic [7:0]        record_opcode;
      logic [7:0]        super_type;
      logic [15:0]       patch_page;
      logic [7:0]        patch_offset;
      logic [31:0]       byte_count;
      logic signed [7:0] shift_amount;
      logic [31:0]       start_offset;
      logic [31:0]       reference_offset;
      logic [15:0]       file_number;
      logic [15:0]       segment_number;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

   function automatic logic [3:0] fields_needed(input logic [7:0] op);
      logic [3:0] n;
      case (op)
         OP_RELOC:     n = 4'd10;
         OP_INTERSEG:  n = 4'd14;
         OP_CRELOC:    n = 4'd6;
         OP_CINTERSEG: n = 4'd7;
         OP_LCONST:    n = 4'd4;
         OP_SUPER:     n = 4'd5;
         default:      n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic rsp_type make_result(input event_type ev, input logic [7:0] op);
      rsp_type r;
      r = '0;
      r.event_res = ev;
      r.record_opcode = op;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/orsp_parse.sv
// Parser core: record phase tracking, field capture and event generation for
// one body byte per transfer, plus the number length register.
// Depends on orsp_pkg.
`default_nettype none

module orsp_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire orsp_pkg::req_type req_data,
   input  wire logic             csr_we,
   input  wire logic [7:0]       csr_wdata,
   output orsp_pkg::push_type    push
);

   orsp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]        record_ff, record_in;
   logic [7:0]        fb_ff [orsp_pkg::FIELD_DEPTH];
   logic [7:0]        fb_in [orsp_pkg::FIELD_DEPTH];
   logic [3:0]        index_ff, index_in;
   logic [31:0]       skip_ff, skip_in;
   logic signed [32:0] remain_ff, remain_in;
   logic [7:0]        kind_ff, kind_in;
   logic [15:0]       page_ff, page_in;
   logic [7:0]        patches_ff, patches_in;
   logic              stopped_ff, stopped_in;
   logic [7:0]        numlen_ff;

   orsp_pkg::phase_type ph;
   logic [7:0]        rec_cur;
   logic [3:0]        idx_cur;
   logic [31:0]       skip_cur;
   logic signed [32:0] rem_cur;
   logic [7:0]        kind_cur;
   logic [15:0]       page_cur;
   logic [7:0]        patches_cur;
   logic              stopped_cur;
   logic [7:0]        b;
   logic [31:0]       raw;
   logic [15:0]       amt;
   logic              check_end;
   orsp_pkg::rsp_type r0, r1;
   logic [1:0]        n_res;

   always_comb begin
      b = req_data.data_byte;
      if (req_data.body_start) begin
         ph          = orsp_pkg::PH_OP;
         rec_cur     = '0;
         idx_cur     = '0;
         skip_cur    = '0;
         rem_cur     = '0;
         kind_cur    = '0;
         page_cur    = '0;
         patches_cur = '0;
         stopped_cur = 1'b0;
      end else begin
         ph          = phase_ff;
         rec_cur     = record_ff;
         idx_cur     = index_ff;
         skip_cur    = skip_ff;
         rem_cur     = remain_ff;
         kind_cur    = kind_ff;
         page_cur    = page_ff;
         patches_cur = patches_ff;
         stopped_cur = stopped_ff;
      end

      phase_in   = ph;
      record_in  = rec_cur;
      index_in   = idx_cur;
      skip_in    = skip_cur;
      remain_in  = rem_cur;
      kind_in    = kind_cur;
      page_in    = page_cur;
      patches_in = patches_cur;
      stopped_in = stopped_cur;
      for (int k = 0; k < orsp_pkg::FIELD_DEPTH; k++) begin
         fb_in[k] = fb_ff[k];
      end
      raw       = '0;
      amt       = '0;
      check_end = 1'b0;
      r0        = '0;
      r1        = '0;
      n_res     = 2'd0;

      if (!stopped_cur) begin
         case (ph)
            orsp_pkg::PH_OP: begin
               record_in = b;
               if (b != orsp_pkg::OP_END && b <= orsp_pkg::OP_CONST_MAX) begin
                  r0 = orsp_pkg::make_result(orsp_pkg::EV_CONST, b);
                  r0.byte_count = {24'd0, b};
                  n_res = 2'd1;
                  skip_in = {24'd0, b};
                  phase_in = orsp_pkg::PH_SKIP;
               end else if (b == orsp_pkg::OP_END) begin
                  r0 = orsp_pkg::make_result(orsp_pkg::EV_END, b);
                  n_res = 2'd1;
                  stopped_in = 1'b1;
               end else if (b == orsp_pkg::OP_DS) begin
                  r0 = orsp_pkg::make_result(orsp_pkg::EV_DS, b);
                  r0.byte_count = {24'd0, numlen_ff};
                  n_res = 2'd1;
                  skip_in = {24'd0, numlen_ff};
                  phase_in = (numlen_ff != 8'd0) ? orsp_pkg::PH_SKIP : orsp_pkg::PH_OP;
               end else if (orsp_pkg::fields_needed(b) != 4'd0) begin
                  index_in = '0;
                  phase_in = orsp_pkg::PH_FIELDS;
               end else begin
                  r0 = orsp_pkg::make_result(orsp_pkg::EV_UNSUPPORTED, b);
                  n_res = 2'd1;
                  stopped_in = 1'b1;
               end
            end
            orsp_pkg::PH_FIELDS: begin
               for (int k = 0; k < orsp_pkg::FIELD_DEPTH; k++) begin
                  if (idx_cur == 4'(k)) begin
                     fb_in[k] = b;
                  end
               end
               index_in = idx_cur + 4'd1;
               if (index_in >= orsp_pkg::fields_needed(rec_cur)) begin
                  phase_in = orsp_pkg::PH_OP;
                  raw = {fb_in[3], fb_in[2], fb_in[1], fb_in[0]};
                  case (rec_cur)
                     orsp_pkg::OP_RELOC: begin
                        r0 = orsp_pkg::make_result(orsp_pkg::EV_RELOC, rec_cur);
                        r0.start_offset = {fb_in[5], fb_in[4], fb_in[3], fb_in[2]};
                        r0.reference_offset = {fb_in[9], fb_in[8], fb_in[7], fb_in[6]};
                     end
                     orsp_pkg::OP_INTERSEG: begin
                        r0 = orsp_pkg::make_result(orsp_pkg::EV_INTERSEG, rec_cur);
                        r0.start_offset = {fb_in[5], fb_in[4], fb_in[3], fb_in[2]};
                        r0.file_number = {fb_in[7], fb_in[6]};
                        r0.segment_number = {fb_in[9], fb_in[8]};
                        r0.reference_offset = {fb_in[13], fb_in[12], fb_in[11], fb_in[10]};
                     end
                     orsp_pkg::OP_CRELOC: begin
                        r0 = orsp_pkg::make_result(orsp_pkg::EV_CRELOC, rec_cur);
                        r0.start_offset = {16'd0, fb_in[3], fb_in[2]};
                        r0.reference_offset = {16'd0, fb_in[5], fb_in[4]};
                     end
                     orsp_pkg::OP_CINTERSEG: begin
                        r0 = orsp_pkg::make_result(orsp_pkg::EV_CINTERSEG, rec_cur);
                        r0.start_offset = {16'd0, fb_in[3], fb_in[2]};
                        r0.file_number = 16'd1;
                        r0.segment_number = {8'd0, fb_in[4]};
                        r0.reference_offset = {16'd0, fb_in[6], fb_in[5]};
                     end
                     orsp_pkg::OP_LCONST: begin
                        r0 = orsp_pkg::make_result(orsp_pkg::EV_LCONST, rec_cur);
                        r0.byte_count = raw;
                        skip_in = raw;
                        phase_in = (raw != 32'd0) ? orsp_pkg::PH_SKIP : orsp_pkg::PH_OP;
                     end
                     default: begin
                        kind_in = fb_in[4];
                        page_in = '0;
                        remain_in = $signed({raw[31], raw}) - 33'sd1;
                        r0 = orsp_pkg::make_result(orsp_pkg::EV_SUPER_HEADER, rec_cur);
                        r0.super_type = fb_in[4];
                        r0.byte_count = raw;
                        check_end = 1'b1;
                     end
                  endcase
                  if (rec_cur != orsp_pkg::OP_LCONST && rec_cur != orsp_pkg::OP_SUPER) begin
                     r0.byte_count = {24'd0, fb_in[0]};
                     r0.shift_amount = fb_in[1];
                  end
                  n_res = 2'd1;
               end
            end
            orsp_pkg::PH_SKIP: begin
               if (skip_cur != 32'd0) begin
                  skip_in = skip_cur - 32'd1;
               end
               if (skip_in == 32'd0) begin
                  phase_in = orsp_pkg::PH_OP;
               end
            end
            orsp_pkg::PH_SBODY: begin
               remain_in = rem_cur - 33'sd1;
               if ((b & orsp_pkg::SKIP_FLAG) != 8'd0) begin
                  amt = {1'b0, b[6:0] & orsp_pkg::SKIP_MASK, 8'd0};
                  r0 = orsp_pkg::make_result(orsp_pkg::EV_SUPER_SKIP, rec_cur);
                  r0.super_type = kind_cur;
                  r0.patch_page = page_cur;
                  r0.byte_count = {16'd0, amt};
                  n_res = 2'd1;
                  page_in = page_cur + amt;
                  check_end = 1'b1;
               end else begin
                  patches_in = b + 8'd1;
                  phase_in = orsp_pkg::PH_SOFFS;
               end
            end
            default: begin
               remain_in = rem_cur - 33'sd1;
               r0 = orsp_pkg::make_result(orsp_pkg::EV_SUPER_PATCH, rec_cur);
               r0.super_type = kind_cur;
               r0.patch_page = page_cur;
               r0.patch_offset = b;
               n_res = 2'd1;
               if (patches_cur != 8'd0) begin
                  patches_in = patches_cur - 8'd1;
               end
               if (patches_in == 8'd0) begin
                  page_in = page_cur + orsp_pkg::PAGE_STEP;
                  check_end = 1'b1;
               end
            end
         endcase

         if (check_end) begin
            if (remain_in == 33'sd0) begin
               r1 = orsp_pkg::make_result(orsp_pkg::EV_SUPER_DONE, rec_cur);
               r1.super_type = kind_in;
               r1.patch_page = page_in;
               n_res = 2'd2;
               phase_in = orsp_pkg::PH_OP;
            end else if (remain_in[32]) begin
               r1 = orsp_pkg::make_result(orsp_pkg::EV_SUPER_ERROR, rec_cur);
               r1.super_type = kind_in;
               r1.patch_page = page_in;
               n_res = 2'd2;
               stopped_in = 1'b1;
               phase_in = orsp_pkg::PH_OP;
            end else begin
               phase_in = orsp_pkg::PH_SBODY;
            end
         end
      end

      r0.last_of_run = (n_res == 2'd1);
      r1.last_of_run = 1'b1;
      push.count = accept ? n_res : 2'd0;
      push.slot0 = r0;
      push.slot1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= orsp_pkg::PH_OP;
         record_ff  <= '0;
         index_ff   <= '0;
         skip_ff    <= '0;
         remain_ff  <= '0;
         kind_ff    <= '0;
         page_ff    <= '0;
         patches_ff <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         record_ff  <= record_in;
         index_ff   <= index_in;
         skip_ff    <= skip_in;
         remain_ff  <= remain_in;
         kind_ff    <= kind_in;
         page_ff    <= page_in;
         patches_ff <= patches_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         numlen_ff <= orsp_pkg::NUMLEN_RESET;
      end else if (csr_we) begin
         numlen_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < orsp_pkg::FIELD_DEPTH; k++) begin
            fb_ff[k] <= fb_in[k];
         end
      end
   end

endmodule

`default_nettype wire

// File: src/object_record_stream_parser_unit.sv
// Top level of the object record stream parser: parser core and result queue.
// Depends on orsp_pkg and orsp_parse.
//
// Usage: body bytes arrive on the req_ channel, one byte per transfer, with
// body_start set on the first byte of a new body, which clears the parser
// before that byte is taken as an opcode. Events leave on the rsp_ channel,
// one per transfer, with last_of_run set on the final event caused by a byte.
// A byte produces zero, one or two events.
// Events are registered in the result queue and offered in order on rsp_.
// Throughput: one byte per cycle while the receiver keeps up and bytes cause
// at most one event; the queue drains at most one event per cycle, so bytes
// that cause two events (SUPER header, skip or page end that closes the
// record) can hold back input. The byte is parsed combinationally against
// the state registers. req_ready is high while the four-entry result queue
// has room for two events, so a stalled receiver holds back input after at
// most four events. The number length register is written through csr_we
// and csr_wdata, takes effect on the next byte, and resets to 4.
// Reset is synchronous: the parser returns to awaiting an opcode, the queue
// empties, and req_ready is high in the first cycle after reset.
`default_nettype none

module object_record_stream_parser_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire orsp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output orsp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata
);

   orsp_pkg::push_type push;
   orsp_pkg::rsp_type  queue_ff [4];
   logic [1:0]         wr_ptr_ff, wr_ptr_in;
   logic [1:0]         rd_ptr_ff, rd_ptr_in;
   logic [2:0]         count_ff, count_in;
   logic               accept;
   logic               pop;

   assign req_ready = (count_ff <= 3'd2);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;

   orsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= push.slot1;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == orsp_pkg::EV_CONST ||
                    rsp_data.event_res == orsp_pkg::EV_DS ||
                    rsp_data.event_res == orsp_pkg::EV_END ||
                    rsp_data.event_res == orsp_pkg::EV_UNSUPPORTED)
      |-> rsp_data.super_type == 8'd0 && rsp_data.patch_page == 16'd0 &&
          rsp_data.last_of_run)
      else $error("plain record event carries SUPER fields or is not last");

endmodule

`default_nettype wire
